FILE: rtl/core/lde_pkg.sv
// Package for the lump directory entry validator.
// Holds the item structs, status and register codes, and sequencer states.
// No dependencies; every other file of the block imports it.
package lde_pkg;

   // Width of a normalized name as stored in the table.
   localparam int NAME_W = 192;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_DIR     = 3'd1,
      ST_DUP     = 3'd2,
      ST_RANGE   = 3'd3,
      ST_EARLIER = 3'd4,
      ST_FULL    = 3'd5
   } lde_status_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_FILE_SIZE   = 3'd0,
      CSR_DIR_START   = 3'd1,
      CSR_DIR_LENGTH  = 3'd2,
      CSR_NATIVE_MODE = 3'd3,
      CSR_MAX_COMP    = 3'd4
   } lde_csr_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIR,
      S_SCAN,
      S_DONE
   } lde_state_type;

   // One input item.
   typedef struct packed {
      logic [63:0] name_bytes_lo;
      logic [63:0] name_bytes_mid;
      logic [63:0] name_bytes_hi;
      logic [63:0] extent_offset;
      logic [63:0] extent_size;
      logic [31:0] compression_code;
      logic        final_entry;
   } lde_req_type;

   // One result item.
   typedef struct packed {
      lde_status_type status;
      logic [5:0]     entry_index;
      logic           directory_ok;
      logic           end_marker;
   } lde_rsp_type;

   // Configuration register set.
   typedef struct packed {
      logic [63:0] file_size;
      logic [63:0] dir_region_start;
      logic [63:0] dir_region_length;
      logic        native_mode;
      logic [31:0] max_compression;
   } lde_cfg_type;

   // One table row: normalized name and extent.
   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [63:0]       start;
      logic [63:0]       length;
   } lde_entry_type;

   // Outputs of the shared compare unit.
   typedef struct packed {
      logic a_below_b_end;
      logic b_below_a_end;
      logic overlap;
   } lde_cmp_res_type;

endpackage

FILE: rtl/core/lde_cmp_unit.sv
// Shared extent compare unit of the lump directory entry validator.
// Exact 65-bit end compares and the overlap test; uses lde_pkg.
module lde_cmp_unit
   import lde_pkg::*;
(
   input  logic [63:0]     a_start,
   input  logic [63:0]     a_len,
   input  logic [63:0]     b_start,
   input  logic [63:0]     b_len,
   output lde_cmp_res_type result
);

   logic [64:0] a_end;
   logic [64:0] b_end;

   // Ends are formed one bit wider so that the sums never wrap.
   assign a_end = {1'b0, a_start} + {1'b0, a_len};
   assign b_end = {1'b0, b_start} + {1'b0, b_len};

   // An empty extent overlaps nothing.
   always_comb begin
      result.a_below_b_end = {1'b0, a_start} < b_end;
      result.b_below_a_end = {1'b0, b_start} < a_end;
      result.overlap       = (a_len != 64'd0) && (b_len != 64'd0) &&
                             result.a_below_b_end && result.b_below_a_end;
   end

endmodule

FILE: rtl/core/lde_store.sv
// Entry table of the lump directory entry validator.
// One write port and one registered read port; uses lde_pkg.
module lde_store
   import lde_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int AW          = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  lde_entry_type wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output lde_entry_type rd_data
);

   lde_entry_type entry_mem [MAX_ENTRIES];
   lde_entry_type rd_data_ff;

   // Table write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lde_ctrl.sv
// Sequencer of the lump directory entry validator.
// Holds the item, walks the table through lde_store and lde_cmp_unit,
// and owns the result register; uses lde_pkg.
module lde_ctrl
   import lde_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int NAME_BYTES  = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  lde_cfg_type cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  lde_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lde_rsp_type rsp_payload
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   lde_state_type     state_ff, state_in;

   // Item registers.
   logic [NAME_W-1:0] name_ff;
   logic              name_bad_ff;
   logic [63:0]       off_ff;
   logic [63:0]       len_ff;
   logic [31:0]       comp_ff;
   logic              last_ff;

   // Check results.
   lde_status_type    early_ff;
   logic              inside_bad_ff;
   logic              comp_bad_ff;
   logic              dir_hit_ff;
   logic              dup_ff;
   logic              ovl_ff;

   // Directory state and scan counters.
   logic [CW-1:0]     held_ff;
   logic              failed_ff;
   logic [CW-1:0]     rd_cnt_ff;
   logic              cmp_vld_ff;

   // Result register.
   logic              rsp_valid_ff;
   lde_rsp_type       rsp_ff;

   // Combinational helpers.
   logic              accept;
   logic              finish;
   logic              issue;
   logic              scan_end;
   logic [NAME_W-1:0] raw_name;
   logic [NAME_W-1:0] norm_name;
   logic              seen_nul;
   lde_status_type    early_c;
   lde_status_type    fin_status;
   logic [63:0]       b_start;
   logic [63:0]       b_len;
   lde_cmp_res_type   cmp_res;
   lde_entry_type     wr_data;
   lde_entry_type     rd_data;
   logic              wr_en;

   // Name normalization: keep bytes up to the first NUL within the name length.
   assign raw_name = {req_payload.name_bytes_hi, req_payload.name_bytes_mid,
                      req_payload.name_bytes_lo};

   always_comb begin
      logic       nul;
      logic [7:0] name_byte;
      nul       = 1'b0;
      norm_name = '0;
      for (int i = 0; i < NAME_W / 8; i++) begin
         name_byte = raw_name[8*i +: 8];
         if (i < NAME_BYTES) begin
            if (name_byte == 8'd0) begin
               nul = 1'b1;
            end
            if (!nul) begin
               norm_name[8*i +: 8] = name_byte;
            end
         end
      end
      seen_nul = nul;
   end

   // Checks that need no table walk.
   always_comb begin
      if (failed_ff) begin
         early_c = ST_EARLIER;
      end else if (held_ff >= CW'(MAX_ENTRIES)) begin
         early_c = ST_FULL;
      end else if (name_bad_ff) begin
         early_c = ST_DIR;
      end else begin
         early_c = ST_OK;
      end
   end

   // Final status, in the priority order of the checks.
   always_comb begin
      if (early_ff != ST_OK) begin
         fin_status = early_ff;
      end else if (dup_ff) begin
         fin_status = ST_DUP;
      end else if (cfg.native_mode && (comp_bad_ff || inside_bad_ff || dir_hit_ff)) begin
         fin_status = ST_RANGE;
      end else if (!cfg.native_mode && inside_bad_ff) begin
         fin_status = ST_RANGE;
      end else if (!cfg.native_mode && dir_hit_ff) begin
         fin_status = ST_DIR;
      end else if (ovl_ff) begin
         fin_status = ST_DIR;
      end else begin
         fin_status = ST_OK;
      end
   end

   assign scan_end = (rd_cnt_ff == held_ff) && !cmp_vld_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = (early_c != ST_OK) ? S_DONE : S_DIR;
         end
         S_DIR: begin
            state_in = (held_ff == '0) ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, compare operands, table access.
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      finish    = 1'b0;
      issue     = 1'b0;
      b_start   = 64'd0;
      b_len     = 64'd0;
      unique case (state_ff)
         S_IDLE: begin
            // The input is held off while reset is high.
            req_stall = reset;
            accept    = req_valid && !reset;
         end
         S_CHECK: begin
            b_start = cfg.file_size;
         end
         S_DIR: begin
            b_start = cfg.dir_region_start;
            b_len   = cfg.dir_region_length;
         end
         S_SCAN: begin
            b_start = rd_data.start;
            b_len   = rd_data.length;
            issue   = rd_cnt_ff != held_ff;
         end
         S_DONE: begin
            finish = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign wr_en          = finish && (fin_status == ST_OK);
   assign wr_data.name   = name_ff;
   assign wr_data.start  = off_ff;
   assign wr_data.length = len_ff;

   // Shared compare unit; the item's extent is always operand a.
   lde_cmp_unit u_cmp (
      .a_start (off_ff),
      .a_len   (len_ff),
      .b_start (b_start),
      .b_len   (b_len),
      .result  (cmp_res)
   );

   // Table of accepted entries.
   lde_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (held_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         failed_ff    <= 1'b0;
         rd_cnt_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            rd_cnt_ff  <= '0;
            cmp_vld_ff <= 1'b0;
         end else if (state_ff == S_SCAN) begin
            if (issue) begin
               rd_cnt_ff <= rd_cnt_ff + CW'(1);
            end
            cmp_vld_ff <= issue;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            if (last_ff) begin
               held_ff   <= '0;
               failed_ff <= 1'b0;
            end else begin
               if (held_ff < CW'(MAX_ENTRIES)) begin
                  held_ff <= held_ff + CW'(1);
               end
               if (fin_status != ST_OK) begin
                  failed_ff <= 1'b1;
               end
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item and check registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         name_ff       <= norm_name;
         name_bad_ff   <= !seen_nul || (norm_name[7:0] == 8'd0);
         off_ff        <= cfg.native_mode ? req_payload.extent_offset
                                          : {32'd0, req_payload.extent_offset[31:0]};
         len_ff        <= cfg.native_mode ? req_payload.extent_size
                                          : {32'd0, req_payload.extent_size[31:0]};
         comp_ff       <= req_payload.compression_code;
         last_ff       <= req_payload.final_entry;
         early_ff      <= ST_OK;
         inside_bad_ff <= 1'b0;
         comp_bad_ff   <= 1'b0;
         dir_hit_ff    <= 1'b0;
         dup_ff        <= 1'b0;
         ovl_ff        <= 1'b0;
      end
      if (state_ff == S_CHECK) begin
         early_ff      <= early_c;
         inside_bad_ff <= cmp_res.b_below_a_end;
         comp_bad_ff   <= comp_ff > cfg.max_compression;
      end
      if (state_ff == S_DIR) begin
         dir_hit_ff <= cmp_res.overlap;
      end
      // The read issued last cycle is compared now.
      if ((state_ff == S_SCAN) && cmp_vld_ff) begin
         if (rd_data.name == name_ff) begin
            dup_ff <= 1'b1;
         end
         if (cmp_res.overlap) begin
            ovl_ff <= 1'b1;
         end
      end
      if (finish) begin
         rsp_ff.status       <= fin_status;
         rsp_ff.entry_index  <= 6'(held_ff);
         rsp_ff.directory_ok <= last_ff && (fin_status == ST_OK);
         rsp_ff.end_marker   <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/lump_directory_entry_validator.sv
// Lump directory entry validator. Takes one directory entry per item and
// returns one result item with its status, its position and, on the final
// entry, the verdict for the whole directory. The time from acceptance to a
// result ready to leave depends on how far the checks get. An entry that
// fails before the table walk goes from the check state straight to done.
// Such an entry follows an earlier failure, arrives with the table full, or
// has a bad name. An entry with no stored entries ahead of it passes through
// the check and directory states only. Any other entry also walks the table
// over the entries already stored for this directory, at most MAX_ENTRIES - 1
// of them, since a full table fails early. The input stalls meanwhile and is
// released when the sequencer returns to idle. The table walk reads and
// compares one stored entry per cycle through a single extent compare unit.
// A finished result sits in an output register, so the next item can be
// accepted while it waits. Configuration writes are taken at any time outside
// reset but must only be made while the block is idle.
// Dependencies: lde_pkg, lde_ctrl, lde_store, lde_cmp_unit.
module lump_directory_entry_validator
   import lde_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int NAME_BYTES  = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lde_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lde_rsp_type rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   lde_cfg_type cfg_ff;

   // Writes are refused while reset is high.
   assign csr_ready = !reset;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FILE_SIZE:   cfg_ff.file_size         <= csr_data;
            CSR_DIR_START:   cfg_ff.dir_region_start  <= csr_data;
            CSR_DIR_LENGTH:  cfg_ff.dir_region_length <= csr_data;
            CSR_NATIVE_MODE: cfg_ff.native_mode       <= csr_data[0];
            CSR_MAX_COMP:    cfg_ff.max_compression   <= csr_data[31:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Entry sequencer with its table and compare unit.
   lde_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NAME_BYTES  (NAME_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: test/lump_directory_entry_validator_tb.sv
// Self-checking testbench for the lump directory entry validator.
// Drives directories of entries, predicts every result and compares it field by field.
// Depends on lde_pkg and on the lump_directory_entry_validator top level.
`timescale 1ns / 1ps

module lump_directory_entry_validator_tb;
   import lde_pkg::*;

   localparam int MAX_ENT = 64;
   localparam int NAME_LEN = 24;
   localparam int NUM_RAND_PHASES = 9;
   localparam int PHASE_ITEMS = 90;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_LIMIT = 100;
   // Highest register index; indexes above CSR_MAX_COMP are unused.
   localparam logic [2:0] CSR_LAST_INDEX = 3'h7;

   // Faults injected into otherwise well-formed directories.
   typedef enum int {
      F_EMPTY,
      F_NO_NUL,
      F_DUP,
      F_OUTSIDE,
      F_OVERLAP,
      F_DIR_HIT,
      F_COMP,
      F_WILD
   } fault_kind;

   // Holds a copy of the table and the registers, predicts each verdict and
   // compares the results against the oldest prediction.
   class directory_checker;
      lde_cfg_type cfg;
      logic [NAME_W-1:0] names [MAX_ENT];
      logic [63:0] starts [MAX_ENT];
      logic [63:0] lengths [MAX_ENT];
      int held;
      bit failed;
      lde_rsp_type verdicts_due [$];
      int errors;

      function new();
         cfg = '0;
         held = 0;
         failed = 0;
         errors = 0;
      endfunction

      function void set_reg(input logic [2:0] idx, input logic [63:0] value);
         case (idx)
            CSR_FILE_SIZE: cfg.file_size = value;
            CSR_DIR_START: cfg.dir_region_start = value;
            CSR_DIR_LENGTH: cfg.dir_region_length = value;
            CSR_NATIVE_MODE: cfg.native_mode = value[0];
            CSR_MAX_COMP: cfg.max_compression = value[31:0];
            default: ;
         endcase
      endfunction

      // Exact x < y + z, computed one bit wider so nothing wraps.
      function bit below_sum(input logic [63:0] x, input logic [63:0] y,
            input logic [63:0] z);
         return {1'b0, x} < ({1'b0, y} + {1'b0, z});
      endfunction

      function bit overlaps(input logic [63:0] a, input logic [63:0] a_len,
            input logic [63:0] b, input logic [63:0] b_len);
         if (a_len == 0 || b_len == 0) return 1'b0;
         return below_sum(a, b, b_len) && below_sum(b, a, a_len);
      endfunction

      function bit in_file(input logic [63:0] off, input logic [63:0] len);
         return off <= cfg.file_size && len <= cfg.file_size - off;
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      // Works out the verdict of one accepted entry and updates the table.
      function void note_entry(input lde_req_type item);
         logic [NAME_W-1:0] raw;
         logic [NAME_W-1:0] key;
         logic [63:0] off;
         logic [63:0] len;
         lde_status_type st;
         lde_rsp_type verdict;
         int pos;
         bit nul_seen;
         bit dir_hit;
         raw = {item.name_bytes_hi, item.name_bytes_mid, item.name_bytes_lo};
         off = item.extent_offset;
         len = item.extent_size;
         if (!cfg.native_mode) begin
            off[63:32] = '0;
            len[63:32] = '0;
         end
         // The name counts only up to its first NUL.
         key = '0;
         nul_seen = 1'b0;
         for (int i = 0; i < NAME_LEN; i++) begin
            if (raw[i*8 +: 8] == 8'h00) nul_seen = 1'b1;
            if (!nul_seen) key[i*8 +: 8] = raw[i*8 +: 8];
         end
         pos = held;
         st = ST_OK;
         if (failed) begin
            st = ST_EARLIER;
         end else if (held >= MAX_ENT) begin
            st = ST_FULL;
         end else if (!nul_seen || key[7:0] == 8'h00) begin
            st = ST_DIR;
         end else begin
            for (int i = 0; i < held; i++) begin
               if (names[i] == key) begin
                  st = ST_DUP;
                  break;
               end
            end
            if (st == ST_OK) begin
               dir_hit = overlaps(off, len, cfg.dir_region_start, cfg.dir_region_length);
               if (cfg.native_mode) begin
                  if (item.compression_code > cfg.max_compression || !in_file(off, len)
                        || dir_hit) st = ST_RANGE;
               end else if (!in_file(off, len)) begin
                  st = ST_RANGE;
               end else if (dir_hit) begin
                  st = ST_DIR;
               end
            end
            if (st == ST_OK) begin
               for (int i = 0; i < held; i++) begin
                  if (overlaps(off, len, starts[i], lengths[i])) begin
                     st = ST_DIR;
                     break;
                  end
               end
            end
         end
         if (st == ST_OK) begin
            names[pos] = key;
            starts[pos] = off;
            lengths[pos] = len;
         end else begin
            failed = 1'b1;
         end
         if (held < MAX_ENT) held++;
         verdict.status = st;
         verdict.entry_index = 6'(pos);
         verdict.directory_ok = item.final_entry && st == ST_OK;
         verdict.end_marker = item.final_entry;
         verdicts_due.push_back(verdict);
         // The final entry closes the directory.
         if (item.final_entry) begin
            held = 0;
            failed = 1'b0;
         end
      endfunction

      function void report(input string field, input int want, input int got);
         errors++;
         // Keep the log short when the block is badly broken.
         if (errors <= REPORT_LIMIT)
            $error("%s: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_verdict(input lde_rsp_type got);
         lde_rsp_type want;
         if (verdicts_due.size() == 0) begin
            report("status (no entry pending)", -1, int'(got.status));
            return;
         end
         want = verdicts_due.pop_front();
         if (got.status !== want.status)
            report("status", int'(want.status), int'(got.status));
         if (got.entry_index !== want.entry_index)
            report("entry_index", int'(want.entry_index), int'(got.entry_index));
         if (got.directory_ok !== want.directory_ok)
            report("directory_ok", int'(want.directory_ok), int'(got.directory_ok));
         if (got.end_marker !== want.end_marker)
            report("end_marker", int'(want.end_marker), int'(got.end_marker));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   lde_req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   lde_rsp_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [63:0] csr_data;

   directory_checker sb;
   bit idle_on;
   bit quiet;
   int sent;
   int cycle_count = 0;

   lump_directory_entry_validator u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Both handshakes are observed with the values held before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_entry(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_verdict(rsp_payload);
      end
   end

   // Result side stalls in random bursts while idling is allowed.
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Uniform-ish value in [0, n); zero when n is zero.
   function automatic logic [64:0] rand_below(input logic [64:0] n);
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      if (n == 0) return '0;
      return 65'(r % {31'd0, n});
   endfunction

   function automatic lde_req_type pack_entry(input logic [NAME_W-1:0] raw,
         input logic [63:0] off, input logic [63:0] size, input logic [31:0] comp,
         input bit last);
      lde_req_type item;
      item.name_bytes_lo = raw[63:0];
      item.name_bytes_mid = raw[127:64];
      item.name_bytes_hi = raw[191:128];
      item.extent_offset = off;
      item.extent_size = size;
      item.compression_code = comp;
      item.final_entry = last;
      return item;
   endfunction

   function automatic lde_req_type make_entry(input string label, input logic [63:0] off,
         input logic [63:0] size, input logic [31:0] comp, input bit last);
      logic [NAME_W-1:0] raw;
      raw = '0;
      for (int i = 0; i < label.len() && i < NAME_LEN; i++) raw[i*8 +: 8] = label[i];
      return pack_entry(raw, off, size, comp, last);
   endfunction

   function automatic lde_cfg_type random_cfg();
      lde_cfg_type c;
      case ($urandom_range(0, 4))
         0: c.file_size = '0;
         1: c.file_size = '1;
         2: c.file_size = rand64();
         3: c.file_size = {32'd0, $urandom};
         default: c.file_size = 64'($urandom_range(1, 1 << 20));
      endcase
      case ($urandom_range(0, 3))
         0: c.dir_region_start = '0;
         1: c.dir_region_start = 64'(rand_below({1'b0, c.file_size} + 65'd1));
         2: c.dir_region_start = '1;
         default: c.dir_region_start = rand64();
      endcase
      case ($urandom_range(0, 3))
         0: c.dir_region_length = '0;
         1: c.dir_region_length = 64'($urandom_range(1, 4096));
         2: c.dir_region_length = '1;
         default: c.dir_region_length = rand64();
      endcase
      c.native_mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: c.max_compression = '0;
         1: c.max_compression = '1;
         2: c.max_compression = 32'($urandom_range(0, 7));
         default: c.max_compression = $urandom;
      endcase
      return c;
   endfunction

   // Writes every register, plus one unused index, holding valid across the burst.
   task automatic write_bank(input lde_cfg_type c);
      logic [2:0] idx [6];
      logic [63:0] val [6];
      logic [63:0] noise;
      noise = rand64();
      idx[0] = CSR_FILE_SIZE;   val[0] = c.file_size;
      idx[1] = CSR_DIR_START;   val[1] = c.dir_region_start;
      idx[2] = CSR_DIR_LENGTH;  val[2] = c.dir_region_length;
      idx[3] = CSR_NATIVE_MODE; val[3] = {noise[63:1], c.native_mode};
      idx[4] = CSR_MAX_COMP;    val[4] = {noise[31:0], c.max_compression};
      idx[5] = 3'($urandom_range(int'(CSR_MAX_COMP) + 1, int'(CSR_LAST_INDEX)));
      val[5] = rand64();
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Offers one item, with an optional gap in front, and returns once it is taken.
   task automatic send_entry(input lde_req_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Sends one directory of well-formed entries laid out beside the directory
   // region, with faults mixed in at the given rate.
   task automatic run_directory(input int count, input int fault_pct, input bit wild);
      logic [NAME_W-1:0] seen_raw [$];
      int seen_len [$];
      logic [63:0] seen_off [$];
      logic [63:0] seen_size [$];
      logic [64:0] cap, dir_end, room_low, room_high, lo, hi, slot, base, size, off;
      logic [NAME_W-1:0] raw;
      logic [63:0] off64, size64;
      logic [31:0] comp;
      int nlen, pick;
      fault_kind fk;
      lde_cfg_type c;
      c = sb.cfg;
      idle_on = !quiet && $urandom_range(0, 3) != 0;
      // Legacy entries keep offset and size inside 32 bits.
      cap = {1'b0, c.file_size};
      if (!c.native_mode && cap > 65'hFFFF_FFFF) cap = 65'hFFFF_FFFF;
      dir_end = {1'b0, c.dir_region_start} + {1'b0, c.dir_region_length};
      room_low = ({1'b0, c.dir_region_start} < cap) ? {1'b0, c.dir_region_start} : cap;
      room_high = (dir_end < cap) ? cap - dir_end : '0;
      lo = '0;
      hi = cap;
      if (c.dir_region_length != 0) begin
         if (room_high > room_low) lo = dir_end;
         else hi = room_low;
      end
      slot = (hi - lo) / 65'(count);
      for (int k = 0; k < count; k++) begin
         // Longer names get a unique second byte, so only one-byte names can repeat.
         nlen = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, NAME_LEN - 1);
         raw = {rand64(), rand64(), rand64()};
         for (int i = 0; i < nlen; i++) raw[i*8 +: 8] = 8'($urandom_range(1, 255));
         if (nlen > 1) raw[15:8] = 8'(k + 1);
         raw[nlen*8 +: 8] = 8'h00;
         base = lo + slot * 65'(k);
         case ($urandom_range(0, 3))
            0: size = '0;
            1: size = rand_below(((slot < 65'd4096) ? slot : 65'd4096) + 65'd1);
            default: size = rand_below(slot + 65'd1);
         endcase
         case ($urandom_range(0, 2))
            0: off = base;
            1: off = base + slot - size;
            default: off = base + rand_below(slot - size + 65'd1);
         endcase
         off64 = off[63:0];
         size64 = size[63:0];
         if (!c.native_mode && $urandom_range(0, 1) == 1) begin
            off64[63:32] = $urandom;
            size64[63:32] = $urandom;
         end
         comp = c.native_mode ? 32'(rand_below({33'd0, c.max_compression} + 65'd1))
                              : $urandom;
         if (wild || $urandom_range(0, 99) < fault_pct) begin
            fk = wild ? F_WILD : fault_kind'($urandom_range(0, int'(F_WILD)));
            case (fk)
               F_EMPTY: raw[7:0] = 8'h00;
               F_NO_NUL: begin
                  for (int i = 0; i < NAME_LEN; i++) raw[i*8 +: 8] = 8'($urandom_range(1, 255));
               end
               F_DUP: begin
                  // Same name up to the NUL, different bytes after it.
                  if (seen_raw.size() > 0) begin
                     pick = $urandom_range(0, seen_raw.size() - 1);
                     raw = seen_raw[pick];
                     for (int i = seen_len[pick] + 1; i < NAME_LEN; i++)
                        raw[i*8 +: 8] = 8'($urandom);
                  end
               end
               F_OUTSIDE: begin
                  off64 = c.file_size - 64'($urandom_range(0, 32));
                  size64 = 64'($urandom_range(1, 64));
               end
               F_OVERLAP: begin
                  if (seen_off.size() > 0) begin
                     pick = $urandom_range(0, seen_off.size() - 1);
                     off64 = seen_off[pick] + 64'(rand_below({1'b0, seen_size[pick]}));
                     size64 = 64'($urandom_range(1, 64));
                  end
               end
               F_DIR_HIT: begin
                  off64 = c.dir_region_start
                        + 64'(rand_below({1'b0, c.dir_region_length} + 65'd1));
                  size64 = 64'($urandom_range(1, 64));
               end
               F_COMP: begin
                  comp = (c.max_compression == '1) ? $urandom
                       : c.max_compression + 32'($urandom_range(1, 4));
               end
               default: begin
                  raw = {rand64(), rand64(), rand64()};
                  off64 = rand64();
                  size64 = rand64();
                  comp = $urandom;
               end
            endcase
         end
         seen_raw.push_back(raw);
         seen_len.push_back(nlen);
         seen_off.push_back(off64);
         seen_size.push_back(size64);
         send_entry(pack_entry(raw, off64, size64, comp, k == count - 1));
      end
   endtask

   initial begin
      lde_cfg_type c;
      lde_req_type d;
      int target, n, kind;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_on = 1'b0;
      quiet = 1'b0;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Legacy directory: file of 1000 bytes, directory region in the first 100.
      c = '{file_size: 64'd1000, dir_region_start: 64'd0, dir_region_length: 64'd100,
            native_mode: 1'b0, max_compression: 32'd3};
      write_bank(c);
      idle_on = 1'b1;
      // An extent touching the region end passes; a repeated name fails and sticks.
      send_entry(make_entry("A", 64'd100, 64'd50, 32'd0, 1'b0));
      d = make_entry("A", 64'd200, 64'd10, 32'd0, 1'b0);
      d.name_bytes_lo[23:16] = 8'h5A;
      send_entry(d);
      send_entry(make_entry("K", 64'd300, 64'd10, 32'd0, 1'b1));
      // Empty name, then a name with no NUL at all.
      send_entry(make_entry("", 64'd300, 64'd10, 32'd0, 1'b0));
      send_entry(make_entry("L", 64'd300, 64'd10, 32'd0, 1'b1));
      send_entry(make_entry("ABCDEFGHIJKLMNOPQRSTUVWX", 64'd300, 64'd10, 32'd0, 1'b1));
      // Extent ending exactly at the file end, then one reaching into the region.
      send_entry(make_entry("B", 64'd950, 64'd50, 32'd0, 1'b0));
      send_entry(make_entry("C", 64'd99, 64'd1, 32'd0, 1'b0));
      send_entry(make_entry("M", 64'd400, 64'd1, 32'd0, 1'b1));
      // Starting at the file end, and out of range and in the region at once.
      send_entry(make_entry("D", 64'd1000, 64'd1, 32'd0, 1'b1));
      send_entry(make_entry("Q", 64'd0, 64'd2000, 32'd0, 1'b1));
      // Upper halves are dropped in legacy mode; an empty extent overlaps nothing.
      send_entry(make_entry("E", 64'h0000_0001_0000_012C, 64'hFFFF_FFFF_0000_0010,
                            32'hFFFF_FFFF, 1'b0));
      send_entry(make_entry("F", 64'd310, 64'd0, 32'd0, 1'b0));
      send_entry(make_entry("G", 64'd310, 64'd5, 32'd0, 1'b1));
      send_entry(make_entry("H", 64'd500, 64'd10, 32'd0, 1'b1));
      req_valid <= 1'b0;
      wait_drained();

      // Native directory over the full 64-bit range, 16-byte region at the file end.
      c = '{file_size: '1, dir_region_start: 64'hFFFF_FFFF_FFFF_FFEF,
            dir_region_length: 64'd16, native_mode: 1'b1, max_compression: 32'd2};
      write_bank(c);
      send_entry(make_entry("ABCDEFGHIJKLMNOPQRSTUVW", 64'd0, 64'hFFFF_FFFF_FFFF_FFEF,
                            32'd2, 1'b0));
      send_entry(make_entry("X", '1, 64'd0, 32'd0, 1'b0));
      send_entry(make_entry("Y", 64'hFFFF_FFFF_FFFF_FFFE, 64'd1, 32'd3, 1'b1));
      send_entry(make_entry("Z", 64'hFFFF_FFFF_FFFF_FFF6, 64'd1, 32'd0, 1'b1));
      send_entry(make_entry("W", 64'd5, '1, 32'd0, 1'b1));
      send_entry(make_entry("V", '1, 64'd1, 32'd0, 1'b1));
      req_valid <= 1'b0;
      wait_drained();

      // Random phases, each under its own register setting.
      for (int p = 0; p < NUM_RAND_PHASES; p++) begin
         if (p == 0)
            c = '{file_size: '1, dir_region_start: 64'd0, dir_region_length: 64'd4096,
                  native_mode: 1'b1, max_compression: '1};
         else
            c = random_cfg();
         write_bank(c);
         quiet = (p == NUM_RAND_PHASES - 1);
         // A clean directory that overflows the table.
         if (p == 0) run_directory(MAX_ENT + 2, 0, 1'b0);
         target = sent + PHASE_ITEMS;
         while (sent < target) begin
            case ($urandom_range(0, 19))
               0: n = $urandom_range(16, 40);
               1: n = 1;
               default: n = $urandom_range(2, 8);
            endcase
            kind = $urandom_range(0, 19);
            run_directory(n, (kind < 8) ? 25 : 0, kind == 0);
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
